[sv/acr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache resolver package
// Shared types, status and command codes, and protocol constants.
// ----------------------------------------------------------------------------
package acr_pkg;

  localparam int TABLE_ENTRIES_DEF = 8;

  // Item commands
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_FRAME  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_SEND     = 3'd1;
  localparam logic [2:0] ST_RESOLVED = 3'd2;
  localparam logic [2:0] ST_FAILED   = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_OWN_IP        = 2'd0;
  localparam logic [1:0] REG_OWN_MAC       = 2'd1;
  localparam logic [1:0] REG_FIRST_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_MAX_TRIES     = 2'd3;

  // Frame checks
  localparam logic [15:0] TYPE_ARP      = 16'h0806;
  localparam logic [15:0] TYPE_RARP     = 16'h8035;
  localparam logic [15:0] HW_ETHER      = 16'h0001;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [15:0] LENS_ETH_IPV4 = 16'h0604;
  localparam logic [15:0] OP_REPLY      = 16'h0002;
  localparam logic [10:0] MIN_LEN       = 11'd28;

  // Reset values
  localparam logic [7:0]  DEFAULT_TIMEOUT = 8'd4;
  localparam logic [3:0]  DEFAULT_TRIES   = 4'd5;
  localparam logic [31:0] NOW_RESET       = 32'd1;

  // Search item travelling down the row of cells
  typedef struct packed {
    logic        valid;
    logic        hit;
    logic        have;
    logic [47:0] hit_mac;
    logic [31:0] pick_time;
  } acr_scan_t;

  // Entry write broadcast to the cells
  typedef struct packed {
    logic        en;
    logic        full;   // write address and MAC as well as the time
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } acr_wr_t;

endpackage

[sv/acr_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache resolver request channel
// Carries lookups, received frames and time ticks.
// ----------------------------------------------------------------------------
interface acr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] lookup_ip;
  logic [10:0] frame_len;
  logic [15:0] ether_type;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [15:0] addr_lens;
  logic [15:0] opcode;
  logic [47:0] sender_hw;
  logic [31:0] sender_proto;
  logic [47:0] target_hw;
  logic [31:0] target_proto;

  modport source (output valid, cmd, lookup_ip, frame_len, ether_type, hw_type, proto_type,
                  addr_lens, opcode, sender_hw, sender_proto, target_hw, target_proto,
                  input ready);
  modport sink (input valid, cmd, lookup_ip, frame_len, ether_type, hw_type, proto_type,
                addr_lens, opcode, sender_hw, sender_proto, target_hw, target_proto,
                output ready);
endinterface

[sv/acr_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache resolver result channel
// Carries hit, request, resolved, failed and busy results.
// ----------------------------------------------------------------------------
interface acr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] hw_addr;
  logic [31:0] source_ip;
  logic [31:0] wanted_ip;

  modport source (output valid, status, hw_addr, source_ip, wanted_ip, input ready);
  modport sink (input valid, status, hw_addr, source_ip, wanted_ip, output ready);
endinterface

[sv/acr_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache resolver configuration channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface acr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/acr_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache resolver cell
// Holds one cache entry, folds it into the passing search item and hands
// the item to the next cell through a register.
// ----------------------------------------------------------------------------
module acr_cell #(
  parameter int SLOT_W   = 3,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        key,
  input  acr_pkg::acr_scan_t pkt_in,
  input  logic [SLOT_W-1:0]  hit_idx_in,
  input  logic [SLOT_W-1:0]  pick_idx_in,
  output acr_pkg::acr_scan_t pkt_out,
  output logic [SLOT_W-1:0]  hit_idx_out,
  output logic [SLOT_W-1:0]  pick_idx_out,
  input  acr_pkg::acr_wr_t   wr,
  input  logic [SLOT_W-1:0]  wr_slot
);

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

  logic [31:0] ip;
  logic [47:0] mac;
  logic [31:0] stamp;

  acr_pkg::acr_scan_t pkt_next;
  logic [SLOT_W-1:0]  hit_idx_next;
  logic [SLOT_W-1:0]  pick_idx_next;
  logic               match;
  logic               take;

  // Compare this entry and update the running hit and oldest pick
  always_comb begin
    pkt_next      = pkt_in;
    hit_idx_next  = hit_idx_in;
    pick_idx_next = pick_idx_in;
    match = (stamp != 32'd0) && (ip == key) && !pkt_in.hit;
    take  = !pkt_in.hit &&
            ((stamp == 32'd0) || !pkt_in.have || (pkt_in.pick_time > stamp));
    if (match) begin
      pkt_next.hit    = 1'b1;
      pkt_next.hit_mac = mac;
      hit_idx_next    = MY_IDX;
    end else if (take) begin
      pkt_next.have      = 1'b1;
      pkt_next.pick_time = stamp;
      pick_idx_next      = MY_IDX;
    end
  end

  // Advance the search item
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out.valid <= 1'b0;
    end else begin
      pkt_out.valid <= pkt_in.valid;
    end
    pkt_out.hit       <= pkt_next.hit;
    pkt_out.have      <= pkt_next.have;
    pkt_out.hit_mac   <= pkt_next.hit_mac;
    pkt_out.pick_time <= pkt_next.pick_time;
    hit_idx_out       <= hit_idx_next;
    pick_idx_out      <= pick_idx_next;
  end

  // Hold the entry; write on a matching slot
  always_ff @(posedge clk) begin
    if (rst) begin
      ip    <= '0;
      mac   <= '0;
      stamp <= '0;
    end else if (wr.en && (wr_slot == MY_IDX)) begin
      stamp <= wr.stamp;
      if (wr.full) begin
        ip  <= wr.ip;
        mac <= wr.mac;
      end
    end
  end

endmodule

[sv/arp_cache_resolver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache resolver
// IP-to-Ethernet address cache with oldest-entry replacement, who-has
// requests, reply checking and timeout retries with doubling span.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     contents
//  cfg      in   valid/ready   index, data (own_ip, own_mac, first_timeout,
//                              max_tries)
//  req      in   valid/ready   cmd and lookup or frame fields
//  rsp      out  valid/ready   status, hw_addr, source_ip, wanted_ip
//
// One item at a time. A tick, frame or busy lookup is handled in the execute
// state; a lookup that searches the table goes on to the search and finish
// states, the search item walking the row of cells one entry per cycle.
// Reset clears the whole table at once; no clearing pass.
// A result held on rsp does not block acceptance; an item that has its own
// result waits at the end of its work until rsp is free.
// ----------------------------------------------------------------------------
module arp_cache_resolver #(
  parameter int TABLE_ENTRIES = acr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  acr_cfg_if.sink   cfg,
  acr_req_if.sink   req,
  acr_rsp_if.source rsp
);

  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Configuration
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [7:0]  first_timeout;
  logic [3:0]  max_tries;

  // Resolver state
  logic [31:0]       now_time, now_time_next;
  logic              waiting, waiting_next;
  logic [31:0]       waiting_ip, waiting_ip_next;
  logic [SLOT_W-1:0] victim_slot, victim_slot_next;
  logic [3:0]        tries_done, tries_done_next;
  logic [31:0]       wait_left, wait_left_next;
  logic [31:0]       wait_span, wait_span_next;

  // Latched item
  logic [1:0]  cmd;
  logic [31:0] lookup_ip;
  logic [10:0] frame_len;
  logic [15:0] ether_type;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [15:0] addr_lens;
  logic [15:0] opcode;
  logic [47:0] sender_hw;
  logic [47:0] target_hw;

  // Search result
  acr_pkg::acr_scan_t fin_pkt;
  logic [SLOT_W-1:0]  fin_hit_idx;
  logic [SLOT_W-1:0]  fin_pick_idx;

  // Result register
  logic        rsp_valid;
  logic [2:0]  rsp_status;
  logic [47:0] rsp_hw_addr;
  logic [31:0] rsp_source_ip;
  logic [31:0] rsp_wanted_ip;

  // Row of cells
  acr_pkg::acr_scan_t chain_pkt  [TABLE_ENTRIES+1];
  logic [SLOT_W-1:0]  chain_hit  [TABLE_ENTRIES+1];
  logic [SLOT_W-1:0]  chain_pick [TABLE_ENTRIES+1];
  acr_pkg::acr_wr_t   wr;
  logic [SLOT_W-1:0]  wr_slot;
  logic               start;

  // Completion control
  logic        res_has;
  logic [2:0]  res_status;
  logic [47:0] res_hw;
  logic [31:0] res_src;
  logic [31:0] res_want;
  logic        res_free;
  logic        commit;
  logic        load;
  logic        frame_ok;
  logic [31:0] now_inc;
  logic [31:0] wl_dec;
  logic [31:0] span_dbl;
  logic [3:0]  tries_inc;

  assign req.ready = (state == S_IDLE) && !rst;
  assign cfg.ready = !rst;
  assign res_free  = !rsp_valid || rsp.ready;

  assign chain_pkt[0]  = '{valid: start, hit: 1'b0, have: 1'b0, hit_mac: '0, pick_time: '0};
  assign chain_hit[0]  = '0;
  assign chain_pick[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    acr_cell #(.SLOT_W(SLOT_W), .CELL_IDX(g)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .key         (lookup_ip),
      .pkt_in      (chain_pkt[g]),
      .hit_idx_in  (chain_hit[g]),
      .pick_idx_in (chain_pick[g]),
      .pkt_out     (chain_pkt[g+1]),
      .hit_idx_out (chain_hit[g+1]),
      .pick_idx_out(chain_pick[g+1]),
      .wr          (wr),
      .wr_slot     (wr_slot)
    );
  end

  // Frame checks
  assign frame_ok = waiting && (frame_len >= acr_pkg::MIN_LEN) &&
                    ((ether_type == acr_pkg::TYPE_ARP) || (ether_type == acr_pkg::TYPE_RARP)) &&
                    (hw_type == acr_pkg::HW_ETHER) && (proto_type == acr_pkg::PROTO_IPV4) &&
                    (addr_lens == acr_pkg::LENS_ETH_IPV4) && (opcode == acr_pkg::OP_REPLY) &&
                    (target_hw == own_mac);

  assign now_inc   = now_time + 32'd1;
  assign wl_dec    = wait_left - 32'd1;
  assign span_dbl  = {wait_span[30:0], 1'b0};
  assign tries_inc = tries_done + 4'd1;

  // Work out the outcome of the current item
  always_comb begin
    res_has    = 1'b0;
    res_status = acr_pkg::ST_HIT;
    res_hw     = '0;
    res_src    = '0;
    res_want   = '0;
    start      = 1'b0;
    wr         = '{en: 1'b0, full: 1'b0, ip: lookup_ip, mac: sender_hw, stamp: now_time};
    wr_slot    = victim_slot;
    now_time_next    = now_time;
    waiting_next     = waiting;
    waiting_ip_next  = waiting_ip;
    victim_slot_next = victim_slot;
    tries_done_next  = tries_done;
    wait_left_next   = wait_left;
    wait_span_next   = wait_span;
    state_next       = state;

    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd)
          acr_pkg::CMD_LOOKUP: begin
            if (waiting) begin
              res_has    = 1'b1;
              res_status = acr_pkg::ST_BUSY;
              res_want   = waiting_ip;
            end
          end
          acr_pkg::CMD_FRAME: begin
            if (frame_ok) begin
              res_has      = 1'b1;
              res_status   = acr_pkg::ST_RESOLVED;
              res_hw       = sender_hw;
              res_want     = waiting_ip;
              wr.full      = 1'b1;
              wr.ip        = waiting_ip;
              waiting_next = 1'b0;
            end
          end
          acr_pkg::CMD_TICK: begin
            now_time_next = (now_inc == 32'd0) ? acr_pkg::NOW_RESET : now_inc;
            if (waiting && (wait_left != 32'd0)) begin
              wait_left_next = wl_dec;
              if (wl_dec == 32'd0) begin
                wait_span_next  = span_dbl;
                tries_done_next = tries_inc;
                res_has         = 1'b1;
                res_want        = waiting_ip;
                if (tries_inc == max_tries) begin
                  waiting_next = 1'b0;
                  res_status   = acr_pkg::ST_FAILED;
                end else begin
                  wait_left_next = span_dbl;
                  res_status     = acr_pkg::ST_SEND;
                  res_hw         = own_mac;
                  res_src        = own_ip;
                end
              end
            end
          end
          default: begin
          end
        endcase
        if ((cmd == acr_pkg::CMD_LOOKUP) && !waiting) begin
          start      = 1'b1;
          state_next = S_SCAN;
        end else if (!res_has || res_free) begin
          state_next = S_IDLE;
        end
        wr.en = (cmd == acr_pkg::CMD_FRAME) && frame_ok && res_free;
      end
      S_SCAN: begin
        if (chain_pkt[TABLE_ENTRIES].valid) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        res_has  = 1'b1;
        res_want = lookup_ip;
        if (fin_pkt.hit) begin
          res_status = acr_pkg::ST_HIT;
          res_hw     = fin_pkt.hit_mac;
          wr_slot    = fin_hit_idx;
          wr.en      = res_free;
        end else if (max_tries == 4'd0) begin
          res_status = acr_pkg::ST_FAILED;
        end else begin
          res_status       = acr_pkg::ST_SEND;
          res_hw           = own_mac;
          res_src          = own_ip;
          victim_slot_next = fin_pick_idx;
          waiting_next     = 1'b1;
          waiting_ip_next  = lookup_ip;
          tries_done_next  = 4'd0;
          wait_span_next   = {24'd0, first_timeout};
          wait_left_next   = {24'd0, first_timeout};
        end
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign commit = ((state == S_EXEC) && !((cmd == acr_pkg::CMD_LOOKUP) && !waiting) &&
                   (!res_has || res_free)) ||
                  ((state == S_FIN) && res_free);
  assign load   = commit && res_has;

  // Advance control and resolver state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      now_time    <= acr_pkg::NOW_RESET;
      waiting     <= 1'b0;
      waiting_ip  <= '0;
      victim_slot <= '0;
      tries_done  <= '0;
      wait_left   <= '0;
      wait_span   <= '0;
    end else begin
      state <= state_next;
      if (commit) begin
        now_time    <= now_time_next;
        waiting     <= waiting_next;
        waiting_ip  <= waiting_ip_next;
        victim_slot <= victim_slot_next;
        tries_done  <= tries_done_next;
        wait_left   <= wait_left_next;
        wait_span   <= wait_span_next;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip        <= '0;
      own_mac       <= '0;
      first_timeout <= acr_pkg::DEFAULT_TIMEOUT;
      max_tries     <= acr_pkg::DEFAULT_TRIES;
    end else if (cfg.valid) begin
      case (cfg.index)
        acr_pkg::REG_OWN_IP:        own_ip        <= cfg.data[31:0];
        acr_pkg::REG_OWN_MAC:       own_mac       <= cfg.data;
        acr_pkg::REG_FIRST_TIMEOUT: first_timeout <= cfg.data[7:0];
        acr_pkg::REG_MAX_TRIES:     max_tries     <= cfg.data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Latch the accepted item and the search result
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd        <= req.cmd;
      lookup_ip  <= req.lookup_ip;
      frame_len  <= req.frame_len;
      ether_type <= req.ether_type;
      hw_type    <= req.hw_type;
      proto_type <= req.proto_type;
      addr_lens  <= req.addr_lens;
      opcode     <= req.opcode;
      sender_hw  <= req.sender_hw;
      target_hw  <= req.target_hw;
    end
    if (chain_pkt[TABLE_ENTRIES].valid) begin
      fin_pkt      <= chain_pkt[TABLE_ENTRIES];
      fin_hit_idx  <= chain_hit[TABLE_ENTRIES];
      fin_pick_idx <= chain_pick[TABLE_ENTRIES];
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
    if (load) begin
      rsp_status    <= res_status;
      rsp_hw_addr   <= res_hw;
      rsp_source_ip <= res_src;
      rsp_wanted_ip <= res_want;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.hw_addr   = rsp_hw_addr;
  assign rsp.source_ip = rsp_source_ip;
  assign rsp.wanted_ip = rsp_wanted_ip;

  // Checks
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!rsp_valid || rsp.ready))
    else $error("result loaded over a pending result");

  a_now_nonzero: assert property (@(posedge clk) disable iff (rst)
    now_time != 32'd0)
    else $error("reference time reads zero");

  a_scan_state: assert property (@(posedge clk) disable iff (rst)
    chain_pkt[TABLE_ENTRIES].valid |-> (state == S_SCAN))
    else $error("search item left the row outside a search");

  a_send_waits: assert property (@(posedge clk) disable iff (rst)
    (load && (res_status == acr_pkg::ST_SEND)) |=> waiting)
    else $error("request sent without waiting for a reply");

endmodule
